[hw/rtl/tkud_pkg.sv]
package tkud_pkg;

	// field widths
	localparam int CNT_W = 13;
	localparam int VAL_W = 16;
	localparam int OKV_W = 8;
	localparam int CFG_W = 16;
	localparam int IDX_W = 3;

	typedef logic [CNT_W-1:0]        count_t;
	typedef logic signed [VAL_W-1:0] value_t;
	typedef logic [OKV_W-1:0]        okval_t;
	typedef logic [CFG_W-1:0]        cfg_data_t;
	typedef logic [IDX_W-1:0]        cfg_idx_t;

	// register indexes
	localparam cfg_idx_t REG_UPDOWN_LOW     = 3'd0;
	localparam cfg_idx_t REG_UPDOWN_HIGH    = 3'd1;
	localparam cfg_idx_t REG_OK_HIGH        = 3'd2;
	localparam cfg_idx_t REG_HOLD_LIMIT     = 3'd3;
	localparam cfg_idx_t REG_REPEAT_BACKOFF = 3'd4;

	// item kinds
	localparam logic KIND_TICK   = 1'b0;
	localparam logic KIND_PRESET = 1'b1;

	// counter thresholds
	localparam count_t RELEASE_CLAMP   = 13'd20;
	localparam count_t SHORT_THRESHOLD = 13'd10;

	// register reset values
	localparam count_t HOLD_RESET    = 13'd5000;
	localparam count_t BACKOFF_RESET = 13'd800;
	localparam okval_t OK_HIGH_RESET = 8'd1;

endpackage

[hw/rtl/three_key_up_down_value_entry.sv]
// channel  | handshake           | payload
// ---------+---------------------+-------------------------------------------------
// in       | in_valid / in_stall | kind, down/up/ok_pressed, preset_updown, preset_ok
// out      | out_valid/out_stall | updown_value, ok_value, press_latched
// cfg      | cfg_wr_en           | cfg_index, cfg_data
//
// an item is taken into the input register and then updates the state registers,
// which double as the result register; one item per cycle while out_stall does not hold a result.
// the input register keeps taking items while a result waits, until it holds one.
// arst_n clears the state and valid registers and loads the register reset values.
module three_key_up_down_value_entry (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_wr_en,
	input  tkud_pkg::cfg_idx_t  cfg_index,
	input  tkud_pkg::cfg_data_t cfg_data,
	// items in
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                kind,
	input  logic                down_pressed,
	input  logic                up_pressed,
	input  logic                ok_pressed,
	input  tkud_pkg::value_t    preset_updown,
	input  tkud_pkg::okval_t    preset_ok,
	// results out
	output logic                out_valid,
	input  logic                out_stall,
	output tkud_pkg::value_t    updown_value,
	output tkud_pkg::okval_t    ok_value,
	output logic                press_latched
);
	import tkud_pkg::*;

	// configuration registers
	value_t updown_low_q;
	value_t updown_high_q;
	okval_t ok_high_q;
	count_t hold_limit_q;
	count_t repeat_backoff_q;

	// input stage
	logic   valid_s1;
	logic   kind_s1;
	logic   down_s1;
	logic   up_s1;
	logic   ok_s1;
	value_t preset_updown_s1;
	okval_t preset_ok_s1;

	// state, also the result
	count_t down_count_q;
	count_t up_count_q;
	count_t ok_count_q;
	logic   press_flag_q;
	value_t setting_q;
	okval_t cycle_q;
	logic   out_valid_q;

	logic   hold;
	logic   advance;

	// next-state logic
	count_t dn_int;
	count_t up_int;
	count_t ok_int;
	logic   ok_fire;
	logic   up_fire;
	logic   dn_fire;
	logic   flag_short;
	okval_t cycle_nx;
	value_t set_short;
	logic   up_rep;
	value_t set_up;
	count_t up_nx;
	logic   dn_rep;
	value_t set_dn;
	count_t dn_nx;
	logic   flag_nx;

	// integrating counter: climb while held, clamp then fall on release
	function automatic count_t integrate(count_t cnt, logic held, count_t limit);
		count_t r;
		r = cnt;
		if (held) begin
			if (cnt < limit) r = cnt + 13'd1;
		end else if (cnt != '0) begin
			r = ((cnt > RELEASE_CLAMP) ? RELEASE_CLAMP : cnt) - 13'd1;
		end
		return r;
	endfunction

	// output stage full and held by the receiver
	assign hold     = out_valid_q && out_stall;
	assign in_stall = valid_s1 && hold;
	assign advance  = valid_s1 && !hold;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			updown_low_q     <= '0;
			updown_high_q    <= '0;
			ok_high_q        <= OK_HIGH_RESET;
			hold_limit_q     <= HOLD_RESET;
			repeat_backoff_q <= BACKOFF_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_UPDOWN_LOW:     updown_low_q     <= value_t'(cfg_data);
				REG_UPDOWN_HIGH:    updown_high_q    <= value_t'(cfg_data);
				REG_OK_HIGH:        ok_high_q        <= cfg_data[OKV_W-1:0];
				REG_HOLD_LIMIT:     hold_limit_q     <= cfg_data[CNT_W-1:0];
				REG_REPEAT_BACKOFF: repeat_backoff_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1          <= kind;
			down_s1          <= down_pressed;
			up_s1            <= up_pressed;
			ok_s1            <= ok_pressed;
			preset_updown_s1 <= preset_updown;
			preset_ok_s1     <= preset_ok;
		end
	end

	// one tick of key processing
	always_comb begin
		dn_int = integrate(down_count_q, down_s1, hold_limit_q);
		up_int = integrate(up_count_q, up_s1, hold_limit_q);
		ok_int = integrate(ok_count_q, ok_s1, hold_limit_q);

		// short action, one per press, priority ok, up, down
		ok_fire    = (ok_int > SHORT_THRESHOLD) && !press_flag_q;
		up_fire    = (up_int > SHORT_THRESHOLD) && !press_flag_q && !ok_fire;
		dn_fire    = (dn_int > SHORT_THRESHOLD) && !press_flag_q && !ok_fire && !up_fire;
		flag_short = press_flag_q || ok_fire || up_fire || dn_fire;

		cycle_nx = cycle_q;
		if (ok_fire) cycle_nx = (cycle_q < ok_high_q) ? cycle_q + 8'd1 : '0;

		set_short = setting_q;
		if (up_fire) begin
			set_short = (setting_q < updown_high_q) ? setting_q + 16'sd1 : updown_low_q;
		end else if (dn_fire) begin
			set_short = (setting_q > updown_low_q) ? setting_q - 16'sd1 : updown_high_q;
		end

		// auto-repeat toward the limits, then back off
		up_rep = (up_int == hold_limit_q) && (set_short < updown_high_q);
		set_up = up_rep ? set_short + 16'sd1 : set_short;
		up_nx  = up_int;
		if (up_rep) up_nx = (up_int > repeat_backoff_q) ? up_int - repeat_backoff_q : '0;

		dn_rep = (dn_int == hold_limit_q) && (set_up > updown_low_q);
		set_dn = dn_rep ? set_up - 16'sd1 : set_up;
		dn_nx  = dn_int;
		if (dn_rep) dn_nx = (dn_int > repeat_backoff_q) ? dn_int - repeat_backoff_q : '0;

		// latch clears once every key has settled
		flag_nx = flag_short && !((up_nx == '0) && (dn_nx == '0) && (ok_int == '0));
	end

	// state and result update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_count_q <= '0;
			up_count_q   <= '0;
			ok_count_q   <= '0;
			press_flag_q <= 1'b0;
			setting_q    <= '0;
			cycle_q      <= '0;
		end else if (advance) begin
			if (kind_s1 == KIND_PRESET) begin
				setting_q <= preset_updown_s1;
				cycle_q   <= preset_ok_s1;
			end else begin
				down_count_q <= dn_nx;
				up_count_q   <= up_nx;
				ok_count_q   <= ok_int;
				press_flag_q <= flag_nx;
				setting_q    <= set_dn;
				cycle_q      <= cycle_nx;
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!hold) begin
			out_valid_q <= valid_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign updown_value  = setting_q;
	assign ok_value      = cycle_q;
	assign press_latched = press_flag_q;

endmodule

[test/tb_three_key_up_down_value_entry.sv]
module tb_three_key_up_down_value_entry;
	timeunit 1ns;
	timeprecision 1ps;

	import tkud_pkg::*;

	localparam int ITEMS_PER_PHASE = 200;
	localparam int PHASES          = 10;
	localparam int PRESSURE_PHASE  = 2;
	localparam int PRESSURE_CYCLES = 300;
	localparam int SETTLE_CYCLES   = 4;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int MAX_LINES       = 40;

	// idling modes, one per phase in rotation
	localparam int MODE_NONE     = 0;
	localparam int MODE_SENDER   = 1;
	localparam int MODE_RECEIVER = 2;
	localparam int MODE_BOTH     = 3;

	typedef struct {
		logic   kind;
		logic   down;
		logic   up;
		logic   ok;
		value_t preset_updown;
		okval_t preset_ok;
	} key_item_t;

	typedef struct {
		value_t updown;
		okval_t okv;
		logic   latched;
	} entry_result_t;

	// predicts the entry values and checks results in order
	class entry_scoreboard;
		int lo_limit, hi_limit, ok_top, hold_top, backoff;
		int cnt_down, cnt_up, cnt_ok;
		bit latched;
		int setting, cycle;
		entry_result_t pending[$];
		int errors;

		function new();
			lo_limit = 0;
			hi_limit = 0;
			ok_top   = int'(OK_HIGH_RESET);
			hold_top = int'(HOLD_RESET);
			backoff  = int'(BACKOFF_RESET);
			cnt_down = 0;
			cnt_up   = 0;
			cnt_ok   = 0;
			latched  = 1'b0;
			setting  = 0;
			cycle    = 0;
			errors   = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, cfg_data_t data);
			case (idx)
				REG_UPDOWN_LOW:     lo_limit = int'($signed(data));
				REG_UPDOWN_HIGH:    hi_limit = int'($signed(data));
				REG_OK_HIGH:        ok_top   = int'(data[OKV_W-1:0]);
				REG_HOLD_LIMIT:     hold_top = int'(data[CNT_W-1:0]);
				REG_REPEAT_BACKOFF: backoff  = int'(data[CNT_W-1:0]);
				default: ;
			endcase
		endfunction

		// integrating debounce: climb while held, clamp then fall on release
		function int integrate(int cnt, bit held);
			if (held) begin
				if (cnt < hold_top)
					cnt++;
			end else if (cnt > 0) begin
				if (cnt > int'(RELEASE_CLAMP))
					cnt = int'(RELEASE_CLAMP);
				cnt--;
			end
			return cnt;
		endfunction

		function int back_off(int cnt);
			return (cnt > backoff) ? cnt - backoff : 0;
		endfunction

		function void note_item(key_item_t it);
			entry_result_t r;
			if (it.kind == KIND_PRESET) begin
				setting = int'(it.preset_updown);
				cycle   = int'(it.preset_ok);
			end else begin
				cnt_down = integrate(cnt_down, it.down);
				cnt_up   = integrate(cnt_up, it.up);
				cnt_ok   = integrate(cnt_ok, it.ok);
				// short actions, ok first, then up, then down
				if (cnt_ok > int'(SHORT_THRESHOLD) && !latched) begin
					latched = 1'b1;
					cycle = (cycle < ok_top) ? cycle + 1 : 0;
				end
				if (cnt_up > int'(SHORT_THRESHOLD) && !latched) begin
					latched = 1'b1;
					setting = (setting < hi_limit) ? setting + 1 : lo_limit;
				end
				if (cnt_down > int'(SHORT_THRESHOLD) && !latched) begin
					latched = 1'b1;
					setting = (setting > lo_limit) ? setting - 1 : hi_limit;
				end
				// auto-repeat on long hold, no wrap
				if (cnt_up == hold_top && setting < hi_limit) begin
					setting++;
					cnt_up = back_off(cnt_up);
				end
				if (cnt_down == hold_top && setting > lo_limit) begin
					setting--;
					cnt_down = back_off(cnt_down);
				end
				if (cnt_up == 0 && cnt_down == 0 && cnt_ok == 0)
					latched = 1'b0;
			end
			r.updown  = value_t'(setting);
			r.okv     = okval_t'(cycle);
			r.latched = latched;
			pending.push_back(r);
		endfunction

		task report(string msg);
			if (errors < MAX_LINES)
				$display("%0t mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(value_t upd, okval_t okv, logic lat);
			entry_result_t want;
			if (pending.size() == 0) begin
				report($sformatf("result with nothing pending (%0d %0d %0b)", upd, okv, lat));
				return;
			end
			want = pending.pop_front();
			if (upd !== want.updown)
				report($sformatf("updown_value got %0d expected %0d", upd, want.updown));
			if (okv !== want.okv)
				report($sformatf("ok_value got %0d expected %0d", okv, want.okv));
			if (lat !== want.latched)
				report($sformatf("press_latched got %0b expected %0b", lat, want.latched));
		endtask
	endclass

	logic      clk;
	logic      arst_n;
	logic      cfg_wr_en;
	cfg_idx_t  cfg_index;
	cfg_data_t cfg_data;
	logic      in_valid;
	logic      in_stall;
	logic      kind;
	logic      down_pressed;
	logic      up_pressed;
	logic      ok_pressed;
	value_t    preset_updown;
	okval_t    preset_ok;
	logic      out_valid;
	logic      out_stall;
	value_t    updown_value;
	okval_t    ok_value;
	logic      press_latched;

	entry_scoreboard sb = new();

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_left     = 0;
	int items_left    = 0;
	int quiet_cycles  = 0;

	three_key_up_down_value_entry u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.down_pressed  (down_pressed),
		.up_pressed    (up_pressed),
		.ok_pressed    (ok_pressed),
		.preset_updown (preset_updown),
		.preset_ok     (preset_ok),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.updown_value  (updown_value),
		.ok_value      (ok_value),
		.press_latched (press_latched)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// offer one item, wait for it to be taken
	task automatic send_item(input key_item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		kind          <= it.kind;
		down_pressed  <= it.down;
		up_pressed    <= it.up;
		ok_pressed    <= it.ok;
		preset_updown <= it.preset_updown;
		preset_ok     <= it.preset_ok;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_item(it);
		items_left--;
	endtask

	// tick item, preset fields carry junk
	task automatic send_tick(input bit d, input bit u, input bit o);
		key_item_t it;
		it.kind          = KIND_TICK;
		it.down          = d;
		it.up            = u;
		it.ok            = o;
		it.preset_updown = value_t'($urandom);
		it.preset_ok     = okval_t'($urandom);
		send_item(it);
	endtask

	// preset item, key levels carry junk
	task automatic send_preset(input value_t v, input okval_t k);
		key_item_t it;
		it.kind          = KIND_PRESET;
		it.down          = 1'($urandom_range(0, 1));
		it.up            = 1'($urandom_range(0, 1));
		it.ok            = 1'($urandom_range(0, 1));
		it.preset_updown = v;
		it.preset_ok     = k;
		send_item(it);
	endtask

	// drop valid and wait until every result is back
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all registers, unused indexes too, upper data bits random above the narrower fields
	task automatic apply_setting(input int lo, input int hi, input int okh, input int hold,
			input int back);
		cfg_data_t d;
		cfg_idx_t  idx[5];
		int        val[5];
		idx = '{REG_UPDOWN_LOW, REG_UPDOWN_HIGH, REG_OK_HIGH, REG_HOLD_LIMIT,
			REG_REPEAT_BACKOFF};
		val = '{lo, hi, okh, hold, back};
		for (int i = 0; i < 5; i++) begin
			d = cfg_data_t'($urandom);
			case (idx[i])
				REG_UPDOWN_LOW, REG_UPDOWN_HIGH: d = cfg_data_t'(val[i]);
				REG_OK_HIGH: d[OKV_W-1:0] = okval_t'(val[i]);
				default: d[CNT_W-1:0] = count_t'(val[i]);
			endcase
			cfg_wr_en <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= d;
			@(posedge clk);
			sb.write_reg(idx[i], d);
		end
		for (int i = int'(REG_REPEAT_BACKOFF) + 1; i < (1 << IDX_W); i++) begin
			d = cfg_data_t'($urandom);
			cfg_wr_en <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data  <= d;
			@(posedge clk);
			sb.write_reg(cfg_idx_t'(i), d);
		end
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// key gestures: full presses, bounces, noise and presets
	task automatic run_random();
		int  r, k, len, span, sel;
		bit  d, u, o;
		int  v;
		while (items_left > 0) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				// press one key (sometimes several), hold, release
				k = $urandom_range(0, 9);
				o = (k < 3) || (k == 9 && $urandom_range(0, 1));
				u = (k >= 3 && k < 6) || (k == 9 && $urandom_range(0, 1));
				d = (k >= 6 && k < 9) || (k == 9 && $urandom_range(0, 1));
				span = (sb.hold_top < 150) ? sb.hold_top : 150;
				len = $urandom_range(1, 3 * span + 25);
				for (int i = 0; i < len && items_left > 0; i++)
					send_tick(d, u, o);
				len = $urandom_range(0, 25);
				for (int i = 0; i < len && items_left > 0; i++)
					send_tick(1'b0, 1'b0, 1'b0);
			end else if (r < 80) begin
				// random levels
				len = $urandom_range(1, 8);
				for (int i = 0; i < len && items_left > 0; i++)
					send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
			end else if (r < 90) begin
				// preset, often at or just past a limit
				sel = $urandom_range(0, 5);
				case (sel)
					0: v = sb.lo_limit - 1;
					1: v = sb.lo_limit;
					2: v = sb.hi_limit;
					3: v = sb.hi_limit + 1;
					default: v = int'($urandom);
				endcase
				send_preset(value_t'(v), okval_t'($urandom));
			end else begin
				// bouncing contact on one key
				k = $urandom_range(0, 2);
				len = $urandom_range(1, 15);
				for (int i = 0; i < len && items_left > 0; i++) begin
					o = (k == 0) && ($urandom_range(0, 3) != 0);
					u = (k == 1) && ($urandom_range(0, 3) != 0);
					d = (k == 2) && ($urandom_range(0, 3) != 0);
					send_tick(d, u, o);
				end
			end
		end
	endtask

	// result side: check taken items, then pick next stall
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_result(updown_value, ok_value, press_latched);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// watchdog on cycles with no item moving
	initial begin
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// main sequence
	initial begin
		int lo, hi, okh, hold, back, t;
		arst_n        <= 1'b0;
		cfg_wr_en     <= 1'b0;
		cfg_index     <= REG_UPDOWN_LOW;
		cfg_data      <= '0;
		in_valid      <= 1'b0;
		kind          <= KIND_TICK;
		down_pressed  <= 1'b0;
		up_pressed    <= 1'b0;
		ok_pressed    <= 1'b0;
		preset_updown <= '0;
		preset_ok     <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: value extremes, all keys at once, preset during a press
		items_left = 24;
		send_preset(16'sh7fff, 8'hff);
		send_preset(16'sh8000, 8'h00);
		send_tick(1'b0, 1'b0, 1'b0);
		repeat (12) send_tick(1'b1, 1'b1, 1'b1);
		send_preset(16'sh0000, 8'hff);
		repeat (8) send_tick(1'b0, 1'b0, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: begin lo = -32768; hi = 32767; okh = 255; hold = 21;   back = 1;    end
				1: begin lo = 5;      hi = -5;    okh = 0;   hold = 8191; back = 8191; end
				2: begin lo = -3;     hi = 3;     okh = 3;   hold = 30;   back = 8191; end
				3: begin lo = 32767;  hi = 32767; okh = 7;   hold = 0;    back = 0;    end
				4: begin lo = -2;     hi = 6;     okh = 2;   hold = 15;   back = 3;    end
				5: begin lo = -32768; hi = -32760; okh = 255; hold = 25;  back = 20;   end
				default: begin
					lo = int'($urandom_range(0, 65535 - 12)) - 32768;
					hi = lo + $urandom_range(0, 12);
					if ($urandom_range(0, 3) == 0) begin
						t = lo;
						lo = hi;
						hi = t;
					end
					okh  = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 5)
						: $urandom_range(0, 255);
					hold = $urandom_range(21, 80);
					back = $urandom_range(1, hold);
				end
			endcase
			apply_setting(lo, hi, okh, hold, back);

			case (p % 4)
				MODE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
				MODE_SENDER:   begin send_idle_pct = 77; stall_pct = 0;  end
				MODE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 77; end
				MODE_BOTH:     begin send_idle_pct = 21; stall_pct = 21; end
				default: ;
			endcase
			// long receiver hold-off so the block backs up into its input
			if (p == PRESSURE_PHASE)
				hold_left = PRESSURE_CYCLES;

			items_left = ITEMS_PER_PHASE;
			run_random();
		end

		settle();
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[files.f]
hw/rtl/tkud_pkg.sv
hw/rtl/three_key_up_down_value_entry.sv
test/tb_three_key_up_down_value_entry.sv
